### hw/rtl/ccc_pkg.sv
// shared types, codes and fixed point helpers for the calibration curve block
// no dependencies
package ccc_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned MagW = 49;  // |dividend| << 16, also widest quotient

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_CONV = 2'd1;
  localparam logic [1:0] OP_FACT = 2'd2;

  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_CURVE = 2'd2;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_GAIN      = 3'd1;
  localparam logic [2:0] REG_COUNT     = 3'd2;
  localparam logic [2:0] REG_MAGNITUDE = 3'd3;
  localparam logic [2:0] REG_HIGH      = 3'd4;
  localparam logic [2:0] REG_LOW       = 3'd5;
  localparam logic [2:0] REG_LINEARITY = 3'd6;

  localparam logic signed [ValW-1:0] VMAX = 32'sh7fff_ffff;
  localparam logic signed [ValW-1:0] VMIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]             op;
    logic [3:0]             point_index;
    logic signed [ValW-1:0] point_x;
    logic signed [ValW-1:0] point_y;
    logic signed [ValW-1:0] absorbance;
    logic signed [ValW-1:0] standard_value;
  } ccc_in_t;

  typedef struct packed {
    logic signed [ValW-1:0] result_value;
    logic                   above_range;
    logic                   below_range;
    logic                   above_high;
    logic                   below_low;
    logic                   above_linearity;
    logic                   divide_error;
  } ccc_out_t;

  typedef struct packed {
    logic            done;
    logic            neg;
    logic [MagW-1:0] quot;
  } ccc_div_res_t;

  // signed saturation of a magnitude and a sign
  function automatic logic signed [ValW-1:0] sat_mag(input logic [MagW-1:0] m,
                                                     input logic neg);
    logic signed [ValW-1:0] r;
    if (neg) begin
      if (m > MagW'(49'h0_8000_0000)) r = VMIN;
      else r = -$signed(m[ValW-1:0]);
    end else begin
      if (m > MagW'(49'h0_7fff_ffff)) r = VMAX;
      else r = $signed(m[ValW-1:0]);
    end
    return r;
  endfunction

  function automatic logic signed [ValW-1:0] clamp33(input logic signed [ValW:0] v);
    logic signed [ValW-1:0] r;
    if (v[ValW] != v[ValW-1]) r = v[ValW] ? VMIN : VMAX;
    else r = v[ValW-1:0];
    return r;
  endfunction

endpackage

### hw/rtl/ccc_div.sv
// restoring divider, one quotient bit per cycle: |num| * 2^16 / |den|
// depends on ccc_pkg
module ccc_div import ccc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [ValW:0]   num_i,
  input  logic signed [ValW:0]   den_i,
  output ccc_div_res_t           res_o
);

  logic [MagW-1:0] dvd_q, dvd_d;
  logic [ValW+1:0] rem_q, rem_d;
  logic [ValW:0]   ud_q, ud_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;
  logic [ValW:0]   un;
  logic [ValW+1:0] rem_sh;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    ud_d   = ud_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    un     = num_i[ValW] ? (ValW+1)'(0) - num_i : num_i;
    rem_sh = {rem_q[ValW:0], dvd_q[MagW-1]};
    if (start_i) begin
      dvd_d = {un, 16'h0000};
      rem_d = '0;
      ud_d  = den_i[ValW] ? (ValW+1)'(0) - den_i : den_i;
      neg_d = num_i[ValW] ^ den_i[ValW];
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // a zero divisor leaves all ones, which saturates as required
      if (rem_sh >= {1'b0, ud_q}) begin
        rem_d = rem_sh - {1'b0, ud_q};
        dvd_d = {dvd_q[MagW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dvd_d = {dvd_q[MagW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(MagW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    ud_q  <= ud_d;
    neg_q <= neg_d;
  end

  assign res_o.done = done_q;
  assign res_o.neg  = neg_q;
  assign res_o.quot = dvd_q;

endmodule

### hw/rtl/ccc_pt_mem.sv
// calibration point store, x and y per slot, one write and one read port
// depends on ccc_pkg
module ccc_pt_mem import ccc_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  logic [2*ValW-1:0]     wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output logic [2*ValW-1:0]     rdata_o
);

  logic [2*ValW-1:0] mem_q [Depth];
  logic [2*ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/ccc_seg_mem.sv
// segment store, slope and intercept per slot; unwritten slots read as zero
// depends on ccc_pkg
module ccc_seg_mem import ccc_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  logic [2*ValW-1:0]     wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output logic [2*ValW-1:0]     rdata_o
);

  logic [2*ValW-1:0] mem_q [Depth];
  logic [2*ValW-1:0] rdata_q;
  logic [Depth-1:0]  vld_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

### hw/rtl/calibration_curve_concentration.sv
// Absorbance to concentration converter with pass-through, single factor and a
// piecewise-linear curve of up to MaxPoints calibration points, Q16.16 throughout.
// One word is in work at a time. A point load and a factor op run through the
// bit-serial divider, and a curve conversion scans the point memory one point at
// a time before it reads the segment and multiplies.
// A finished word waits in the output register while the next word is taken.
// depends on ccc_pkg, ccc_div, ccc_pt_mem, ccc_seg_mem
module calibration_curve_concentration import ccc_pkg::*; #(
  parameter int unsigned MaxPoints = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ccc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ccc_out_t    out_data_o
);

  localparam int unsigned AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_LD   = 12'b0000_0000_0010,
    S_LD2  = 12'b0000_0000_0100,
    S_DIV  = 12'b0000_0000_1000,
    S_SCAN = 12'b0000_0001_0000,
    S_SCMP = 12'b0000_0010_0000,
    S_SEG  = 12'b0000_0100_0000,
    S_SEGD = 12'b0000_1000_0000,
    S_MUL  = 12'b0001_0000_0000,
    S_MUL2 = 12'b0010_0000_0000,
    S_FIN  = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_e;

  state_e st_q, st_d;

  // configuration
  logic [1:0]             mode_q;
  logic signed [ValW-1:0] gain_q, high_q, low_q, lin_q;
  logic [4:0]             count_q;
  logic                   mag_q;

  // item in work
  logic [1:0]             op_q, op_d;
  logic [3:0]             k_q, k_d;
  logic signed [ValW-1:0] px_q, px_d, py_q, py_d, ab_q, ab_d, sv_q, sv_d;
  logic [AddrW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [ValW-1:0] res_q, res_d, icpt_q, icpt_d;
  logic signed [ValW-1:0] mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic [47:0]            prod_q, prod_d;
  logic                   pneg_q, pneg_d;
  logic                   ar_q, ar_d, br_q, br_d, ah_q, ah_d, bl_q, bl_d;
  logic                   al_q, al_d, de_q, de_d;

  ccc_out_t out_q, out_d;
  logic     out_valid_q, out_valid_d;

  // memories and divider
  logic                   pt_we, seg_we, div_start;
  logic [AddrW-1:0]       pt_waddr, pt_raddr, seg_raddr;
  logic [2*ValW-1:0]      pt_rdata, seg_rdata, seg_wdata;
  logic signed [ValW:0]   div_num, div_den;
  ccc_div_res_t           div_res;

  logic signed [ValW-1:0] x_rd, y_rd, q_sat, p_sat, r_fin;
  logic signed [ValW:0]   dx, dy;
  logic [ValW-1:0]        ua, ub;
  logic [2*ValW-1:0]      prod_full;
  logic                   k_ok;

  ccc_pt_mem #(.Depth(MaxPoints), .AddrW(AddrW)) u_pt_mem (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i ({px_q, py_q}),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  ccc_seg_mem #(.Depth(MaxPoints), .AddrW(AddrW)) u_seg_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (seg_we),
    .waddr_i (pt_waddr),
    .wdata_i (seg_wdata),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  ccc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 2'd1;
      gain_q  <= 32'sd65536;
      count_q <= '0;
      mag_q   <= 1'b0;
      high_q  <= VMAX;
      low_q   <= VMIN;
      lin_q   <= VMAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:      mode_q  <= cfg_wdata_i[1:0];
        REG_GAIN:      gain_q  <= $signed(cfg_wdata_i);
        REG_COUNT:     count_q <= cfg_wdata_i[4:0];
        REG_MAGNITUDE: mag_q   <= cfg_wdata_i[0];
        REG_HIGH:      high_q  <= $signed(cfg_wdata_i);
        REG_LOW:       low_q   <= $signed(cfg_wdata_i);
        REG_LINEARITY: lin_q   <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign x_rd      = $signed(pt_rdata[2*ValW-1:ValW]);
  assign y_rd      = $signed(pt_rdata[ValW-1:0]);
  assign dx        = {px_q[ValW-1], px_q} - {x_rd[ValW-1], x_rd};
  assign dy        = {py_q[ValW-1], py_q} - {y_rd[ValW-1], y_rd};
  assign q_sat     = sat_mag(div_res.quot, div_res.neg);
  assign p_sat     = sat_mag({1'b0, prod_q}, pneg_q);
  assign ua        = mul_a_q[ValW-1] ? ValW'(0) - mul_a_q : mul_a_q;
  assign ub        = mul_b_q[ValW-1] ? ValW'(0) - mul_b_q : mul_b_q;
  assign prod_full = ua * ub;
  assign k_ok      = (32'(k_q) < MaxPoints);
  assign pt_waddr  = AddrW'(k_q);
  assign seg_wdata = {mul_b_q, icpt_q};
  assign div_num   = (op_q == OP_LOAD) ? dy : {sv_q[ValW-1], sv_q};
  assign div_den   = (op_q == OP_LOAD) ? dx : {ab_q[ValW-1], ab_q};
  assign r_fin     = (mag_q && res_q[ValW-1]) ? clamp33(-{res_q[ValW-1], res_q}) : res_q;

  always_comb begin
    st_d    = st_q;
    op_d    = op_q;
    k_d     = k_q;
    px_d    = px_q;
    py_d    = py_q;
    ab_d    = ab_q;
    sv_d    = sv_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    icpt_d  = icpt_q;
    mul_a_d = mul_a_q;
    mul_b_d = mul_b_q;
    prod_d  = prod_q;
    pneg_d  = pneg_q;
    ar_d    = ar_q;
    br_d    = br_q;
    ah_d    = ah_q;
    bl_d    = bl_q;
    al_d    = al_q;
    de_d    = de_q;
    out_d   = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pt_we     = 1'b0;
    seg_we    = 1'b0;
    div_start = 1'b0;
    pt_raddr  = idx_q;
    seg_raddr = idx_q;

    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_data_i.op;
          k_d    = in_data_i.point_index;
          px_d   = in_data_i.point_x;
          py_d   = in_data_i.point_y;
          ab_d   = in_data_i.absorbance;
          sv_d   = in_data_i.standard_value;
          res_d  = '0;
          icpt_d = '0;
          idx_d  = '0;
          ar_d   = 1'b0;
          br_d   = 1'b0;
          ah_d   = 1'b0;
          bl_d   = 1'b0;
          al_d   = 1'b0;
          de_d   = 1'b0;
          unique case (in_data_i.op)
            OP_LOAD: st_d = S_LD;
            OP_CONV: begin
              if (mode_q == MODE_PASS) begin
                res_d = in_data_i.absorbance;
                st_d  = S_OUT;
              end else if (mode_q == MODE_CURVE) begin
                if (32'(count_q) > MaxPoints) cnt_d = CntW'(MaxPoints);
                else cnt_d = CntW'(count_q);
                if (count_q == 5'd0) begin
                  ar_d = 1'b1;
                  st_d = S_OUT;
                end else begin
                  st_d = S_SCAN;
                end
              end else begin
                mul_a_d = in_data_i.absorbance;
                mul_b_d = gain_q;
                st_d    = S_MUL;
              end
            end
            OP_FACT: st_d = S_LD2;
            default: st_d = S_OUT;
          endcase
        end
      end
      S_LD: begin
        // store the point and fetch the one below it
        if (!k_ok) begin
          st_d = S_OUT;
        end else begin
          pt_we    = 1'b1;
          pt_raddr = AddrW'(k_q) - AddrW'(1);
          st_d     = (k_q == 4'd0) ? S_OUT : S_LD2;
        end
      end
      S_LD2: begin
        div_start = 1'b1;
        de_d      = (div_den == '0);
        st_d      = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          if (op_q == OP_LOAD) begin
            mul_a_d = px_q;
            mul_b_d = q_sat;
            st_d    = S_MUL;
          end else begin
            res_d = q_sat[ValW-1] ? clamp33(-{q_sat[ValW-1], q_sat}) : q_sat;
            st_d  = S_OUT;
          end
        end
      end
      S_SCAN: st_d = S_SCMP;
      S_SCMP: begin
        if (ab_q < x_rd) begin
          if (idx_q == '0) begin
            br_d = 1'b1;
            st_d = S_OUT;
          end else begin
            st_d = S_SEG;
          end
        end else if ((CntW'(idx_q) + CntW'(1)) == cnt_q) begin
          ar_d = 1'b1;
          st_d = S_SEG;
        end else begin
          idx_d = idx_q + AddrW'(1);
          st_d  = S_SCAN;
        end
      end
      S_SEG: st_d = S_SEGD;
      S_SEGD: begin
        mul_a_d = ab_q;
        mul_b_d = $signed(seg_rdata[2*ValW-1:ValW]);
        icpt_d  = $signed(seg_rdata[ValW-1:0]);
        st_d    = S_MUL;
      end
      S_MUL: begin
        prod_d = prod_full[2*ValW-1:16];
        pneg_d = mul_a_q[ValW-1] ^ mul_b_q[ValW-1];
        st_d   = S_MUL2;
      end
      S_MUL2: begin
        if (op_q == OP_LOAD) begin
          icpt_d = clamp33({py_q[ValW-1], py_q} - {p_sat[ValW-1], p_sat});
          st_d   = S_FIN;
        end else begin
          res_d = clamp33({p_sat[ValW-1], p_sat} + {icpt_q[ValW-1], icpt_q});
          st_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (op_q == OP_LOAD) begin
          seg_we = 1'b1;
        end else begin
          res_d = r_fin;
          if (!ar_q && !br_q) begin
            ah_d = high_q < r_fin;
            al_d = lin_q < r_fin;
            bl_d = low_q > r_fin;
          end
        end
        st_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.result_value    = res_q;
          out_d.above_range     = ar_q;
          out_d.below_range     = br_q;
          out_d.above_high      = ah_q;
          out_d.below_low       = bl_q;
          out_d.above_linearity = al_q;
          out_d.divide_error    = de_q;
          out_valid_d           = 1'b1;
          st_d                  = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    k_q     <= k_d;
    px_q    <= px_d;
    py_q    <= py_d;
    ab_q    <= ab_d;
    sv_q    <= sv_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    icpt_q  <= icpt_d;
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    prod_q  <= prod_d;
    pneg_q  <= pneg_d;
    ar_q    <= ar_d;
    br_q    <= br_d;
    ah_q    <= ah_d;
    bl_q    <= bl_d;
    al_q    <= al_d;
    de_q    <= de_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/sv/calibration_curve_concentration_test.sv
// self-checking testbench for calibration_curve_concentration: directed corner
// words, then random phases under several register settings; depends on ccc_pkg and calibration_curve_concentration
module calibration_curve_concentration_test import ccc_pkg::*;;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam logic [1:0] MODE_FACTOR = 2'd1;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int unsigned NumPts     = 16;
  localparam int unsigned StallLimit = 3000;

  // tracks registers and point tables, predicts each result word
  class conc_scoreboard;
    logic [1:0]             mode_r;
    logic signed [ValW-1:0] gain_r, high_r, low_r, lin_r;
    logic [4:0]             count_r;
    logic                   mag_r;
    logic signed [ValW-1:0] px [NumPts];
    logic signed [ValW-1:0] py [NumPts];
    logic signed [ValW-1:0] slope [NumPts];
    logic signed [ValW-1:0] icpt [NumPts];
    ccc_out_t               pending_q [$];
    int                     errors, checked;

    function new();
      mode_r = MODE_FACTOR; gain_r = 32'sd65536; count_r = 0; mag_r = 0;
      high_r = VMAX; low_r = VMIN; lin_r = VMAX;
      for (int i = 0; i < NumPts; i++) begin
        px[i] = 0; py[i] = 0; slope[i] = 0; icpt[i] = 0;
      end
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_MODE:      mode_r = d[1:0];
        REG_GAIN:      gain_r = d;
        REG_COUNT:     count_r = d[4:0];
        REG_MAGNITUDE: mag_r = d[0];
        REG_HIGH:      high_r = d;
        REG_LOW:       low_r = d;
        REG_LINEARITY: lin_r = d;
        default: ;
      endcase
    endfunction

    function logic signed [ValW-1:0] sat(longint unsigned m, bit neg);
      if (neg) return (m > 64'h8000_0000) ? VMIN : ValW'(-m);
      return (m > 64'h7fff_ffff) ? VMAX : ValW'(m);
    endfunction

    function logic signed [ValW-1:0] clampv(longint v);
      if (v > longint'(VMAX)) return VMAX;
      if (v < longint'(VMIN)) return VMIN;
      return ValW'(v);
    endfunction

    function longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    function logic signed [ValW-1:0] qmul(longint a, longint b);
      return sat((mag(a) * mag(b)) >> 16, (a < 0) != (b < 0));
    endfunction

    function logic signed [ValW-1:0] qdiv(longint num, longint den, inout bit err);
      if (den == 0) begin
        err = 1;
        return (num < 0) ? VMIN : VMAX;
      end
      return sat((mag(num) << 16) / mag(den), (num < 0) != (den < 0));
    endfunction

    function void note_input(ccc_in_t w);
      ccc_out_t e;
      bit       de;
      int       cnt;
      bit       found;
      longint   res;
      e = '0; de = 0; res = 0; found = 0;
      case (w.op)
        OP_LOAD: begin
          px[w.point_index] = w.point_x;
          py[w.point_index] = w.point_y;
          if (w.point_index != 0) begin
            slope[w.point_index] = qdiv(longint'(w.point_y) - py[w.point_index-1],
                                        longint'(w.point_x) - px[w.point_index-1], de);
            icpt[w.point_index] = clampv(longint'(w.point_y) -
                                         qmul(w.point_x, slope[w.point_index]));
          end
        end
        OP_CONV: begin
          if (mode_r == MODE_PASS) res = w.absorbance;
          else begin
            if (mode_r == MODE_CURVE) begin
              cnt = (count_r > NumPts) ? NumPts : count_r;
              for (int i = 0; i < cnt && !found; i++) begin
                if (w.absorbance < px[i]) begin
                  found = 1;
                  if (i == 0) e.below_range = 1;
                  else res = clampv(longint'(qmul(w.absorbance, slope[i])) + icpt[i]);
                end
              end
              if (!found) begin
                e.above_range = 1;
                if (cnt != 0)
                  res = clampv(longint'(qmul(w.absorbance, slope[cnt-1])) + icpt[cnt-1]);
              end
            end else res = qmul(w.absorbance, gain_r);
            if (mag_r && res < 0) res = clampv(-res);
            if (!e.above_range && !e.below_range) begin
              e.above_high      = longint'(high_r) < res;
              e.above_linearity = longint'(lin_r) < res;
              e.below_low       = longint'(low_r) > res;
            end
          end
        end
        OP_FACT: begin
          res = qdiv(w.standard_value, w.absorbance, de);
          if (res < 0) res = clampv(-res);
        end
        default: ;
      endcase
      e.result_value = ValW'(res);
      e.divide_error = de;
      pending_q.push_back(e);
    endfunction

    function void check_result(ccc_out_t got);
      ccc_out_t    e;
      logic [5:0]  ef, gf;
      string       names [6];
      names = '{"above_range", "below_range", "above_high", "below_low",
                "above_linearity", "divide_error"};
      if (pending_q.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.result_value !== e.result_value) begin
        $display("%0t result_value expected %h actual %h", $time,
                 e.result_value, got.result_value);
        errors++;
      end
      ef = e[5:0]; gf = got[5:0];
      for (int i = 0; i < 6; i++)
        if (gf[5-i] !== ef[5-i]) begin
          $display("%0t %s expected %b actual %b", $time, names[i], ef[5-i], gf[5-i]);
          errors++;
        end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  ccc_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  ccc_out_t    out_data_o;

  conc_scoreboard sb = new();
  bit          calm = 0;
  int          quiet_cycles = 0;
  int          words_sent = 0;

  calibration_curve_concentration dut (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // result side: check accepted words and keep the watchdog
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("calibration_curve_concentration_test: errors");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    forever begin
      if (calm) begin
        out_stall_i <= 0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  task automatic send_word(ccc_in_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
    words_sent++;
  endtask

  // stop sending and wait for every expected word plus a short settle
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_we_i    <= 1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
  endtask

  task automatic end_cfg();
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic ccc_in_t make_word(logic [1:0] op, logic [3:0] k, logic [31:0] x,
                                        logic [31:0] y, logic [31:0] ab, logic [31:0] sv);
    ccc_in_t w;
    w.op = op; w.point_index = k; w.point_x = x; w.point_y = y;
    w.absorbance = ab; w.standard_value = sv;
    return w;
  endfunction

  // rising x points with random content; now and then a repeated x or a dip
  task automatic load_curve(bit wide);
    logic signed [31:0] x, y;
    x = -$signed(32'($urandom_range(0, 400000)));
    for (int i = 0; i < NumPts; i++) begin
      y = wide ? $urandom : 32'($urandom_range(0, 600000)) - 32'sd100000;
      send_word(make_word(OP_LOAD, 4'(i), x, y, $urandom, $urandom));
      case ($urandom_range(0, 9))
        0: ;
        1: x = x - 32'($urandom_range(1, 30000));
        default: x = x + 32'($urandom_range(1, 60000));
      endcase
    end
  endtask

  function automatic ccc_in_t rand_word(bit curve);
    ccc_in_t w;
    int      r;
    w = make_word(OP_CONV, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
    r = $urandom_range(0, 19);
    if (r < 2) w.op = OP_LOAD;
    else if (r < 4) w.op = OP_FACT;
    else if (r == 4) w.op = OP_NONE;
    if (curve && w.op == OP_CONV && $urandom_range(0, 4) != 0)
      w.absorbance = sb.px[$urandom_range(0, NumPts-1)] +
                     32'($urandom_range(0, 1024)) - 32'sd512;
    else if (!curve && $urandom_range(0, 1) == 0)
      w.absorbance = 32'($urandom_range(0, 1 << 20)) - 32'sd524288;
    return w;
  endfunction

  task automatic run_phase(int n, bit curve);
    for (int i = 0; i < n; i++) send_word(rand_word(curve));
    drain();
  endtask

  task automatic set_limits(bit narrow);
    if (narrow) begin
      write_reg(REG_HIGH, 32'($urandom_range(0, 300000)));
      write_reg(REG_LOW, -32'($urandom_range(0, 300000)));
      write_reg(REG_LINEARITY, 32'($urandom_range(0, 500000)));
    end else begin
      write_reg(REG_HIGH, $urandom);
      write_reg(REG_LOW, $urandom);
      write_reg(REG_LINEARITY, $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // factor mode at reset values, extremes, zero divisors, unused op
    send_word(make_word(OP_CONV, 0, 0, 0, VMAX, 0));
    send_word(make_word(OP_CONV, 0, 0, 0, VMIN, 0));
    send_word(make_word(OP_CONV, 0, 0, 0, 0, 0));
    send_word(make_word(OP_FACT, 0, 0, 0, 0, VMIN));
    send_word(make_word(OP_FACT, 0, 0, 0, 0, 32'sd65536));
    send_word(make_word(OP_FACT, 0, 0, 0, 32'sd1, VMIN));
    send_word(make_word(OP_FACT, 0, 0, 0, -32'sd3, 32'sd65536));
    send_word(make_word(OP_NONE, 4'hf, VMAX, VMIN, VMAX, VMIN));
    // fill every slot in order, then two zero dx loads and stale segments
    load_curve(0);
    send_word(make_word(OP_LOAD, 15, sb.px[14], sb.py[14] + 32'sd7, 0, 0));
    send_word(make_word(OP_LOAD, 14, sb.px[13], -32'sd5, 0, 0));
    send_word(make_word(OP_LOAD, 3, sb.px[3] + 32'sd100, sb.py[3] - 32'sd9, 0, 0));
    drain();

    write_reg(REG_MODE, MODE_CURVE);
    write_reg(REG_COUNT, 0);
    end_cfg();
    send_word(make_word(OP_CONV, 0, 0, 0, 32'sd1234, 0));
    drain();
    write_reg(REG_COUNT, 16);
    write_reg(REG_MAGNITUDE, 1);
    end_cfg();
    send_word(make_word(OP_CONV, 0, 0, 0, VMIN, 0));
    send_word(make_word(OP_CONV, 0, 0, 0, VMAX, 0));
    send_word(make_word(OP_CONV, 0, 0, 0, sb.px[4] - 32'sd1, 0));
    send_word(make_word(OP_CONV, 0, 0, 0, sb.px[0], 0));
    drain();
    write_reg(REG_COUNT, 31);
    end_cfg();
    send_word(make_word(OP_CONV, 0, 0, 0, sb.px[15], 0));
    drain();
    write_reg(REG_MODE, MODE_SPARE);
    write_reg(REG_GAIN, 32'sd65536);
    end_cfg();
    send_word(make_word(OP_CONV, 0, 0, 0, VMIN, 0));
    drain();
    write_reg(REG_MODE, MODE_PASS);
    end_cfg();
    send_word(make_word(OP_CONV, 0, 0, 0, VMIN, 0));
    drain();

    // random phases
    write_reg(REG_MODE, MODE_FACTOR);
    write_reg(REG_GAIN, $urandom);
    write_reg(REG_MAGNITUDE, 0);
    set_limits(1);
    end_cfg();
    run_phase(50, 0);

    write_reg(REG_MODE, MODE_PASS);
    set_limits(0);
    end_cfg();
    run_phase(40, 0);

    write_reg(REG_MODE, MODE_CURVE);
    write_reg(REG_COUNT, 16);
    write_reg(REG_MAGNITUDE, 1);
    set_limits(1);
    end_cfg();
    load_curve(0);
    run_phase(50, 1);

    write_reg(REG_COUNT, $urandom_range(1, 15));
    write_reg(REG_MAGNITUDE, 0);
    end_cfg();
    load_curve(1);
    run_phase(45, 1);

    write_reg(REG_COUNT, $urandom_range(17, 31));
    end_cfg();
    run_phase(35, 1);

    write_reg(REG_MODE, MODE_SPARE);
    write_reg(REG_GAIN, VMIN);
    write_reg(REG_MAGNITUDE, 1);
    end_cfg();
    run_phase(35, 0);

    write_reg(REG_MODE, MODE_FACTOR);
    write_reg(REG_GAIN, VMAX);
    write_reg(REG_HIGH, VMIN);
    write_reg(REG_LOW, VMAX);
    write_reg(REG_LINEARITY, VMIN);
    end_cfg();
    run_phase(35, 0);

    // last stretch without idling on either side
    calm = 1;
    write_reg(REG_MODE, MODE_CURVE);
    write_reg(REG_COUNT, 16);
    set_limits(1);
    end_cfg();
    load_curve(0);
    run_phase(60, 1);

    $display("sent %0d words over all modes and register extremes, %0d results checked",
             words_sent, sb.checked);
    if (sb.errors == 0) $display("calibration_curve_concentration_test: clean");
    else $display("calibration_curve_concentration_test: errors");
    $finish;
  end

endmodule

### files.f
hw/rtl/ccc_pkg.sv
hw/rtl/ccc_div.sv
hw/rtl/ccc_pt_mem.sv
hw/rtl/ccc_seg_mem.sv
hw/rtl/calibration_curve_concentration.sv
tb/sv/calibration_curve_concentration_test.sv
